@@ src/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, constants and helpers of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int ARENA_GRANULES = 4096;
    localparam int LW = $clog2(ARENA_GRANULES) + 1;   // link / size width
    localparam int IW = $clog2(ARENA_GRANULES);       // granule index width
    localparam logic [LW-1:0] NULL_LINK = LW'(ARENA_GRANULES);

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam logic [0:0] CMD_ALLOC = 1'b0;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_INIT     = 4'd1;
    localparam logic [3:0] OP_START    = 4'd2;
    localparam logic [3:0] OP_RD_CUR   = 4'd3;
    localparam logic [3:0] OP_STEP     = 4'd4;
    localparam logic [3:0] OP_FIT      = 4'd5;
    localparam logic [3:0] OP_WR_REM   = 4'd6;
    localparam logic [3:0] OP_WR_PREVA = 4'd7;
    localparam logic [3:0] OP_WR_CUR   = 4'd8;
    localparam logic [3:0] OP_RD_T     = 4'd9;
    localparam logic [3:0] OP_LATCH_T  = 4'd10;
    localparam logic [3:0] OP_LATCH_NX = 4'd11;
    localparam logic [3:0] OP_WR_PMRG  = 4'd12;
    localparam logic [3:0] OP_WR_PLINK = 4'd13;
    localparam logic [3:0] OP_WR_T     = 4'd14;

    typedef struct packed {
        logic [LW-1:0] next;
        logic [LW-1:0] size;
    } t_hdr;

    typedef struct packed {
        logic [3:0] op;
        logic       emit;
        logic [1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic zero_req;
        logic walk_ok;
        logic fit;
        logic split;
        logic t_oor;
        logic walk_more;
        logic nmerge;
        logic prev_adj;
    } t_dp_stat;

    // chunk size forced into [1, arena end - c]
    function automatic logic [LW-1:0] eff_size(input logic [LW-1:0] c,
                                               input logic [LW-1:0] s,
                                               input logic [LW-1:0] arena);
        logic [LW-1:0] room;
        logic [LW-1:0] s1;
        room = arena - c;
        s1   = (s == '0) ? LW'(1) : s;
        return (s1 > room) ? room : s1;
    endfunction

endpackage

@@ src/first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over 16-byte granules with an address-ordered free list.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a request by raising start while busy is low; i_cmd selects allocate
//   or free. One result per item appears on o_status / o_granted_offset for a
//   single cycle with o_valid high; the receiver cannot stall it.
//   Allocate walks the free list until a chunk fits or the list ends (a zero-size
//   request returns without a walk); free walks the chunks below the freed one,
//   and a chunk outside the arena returns without a walk. Items are worked one
//   at a time, and busy stays high while the list is walked through the header
//   RAM's single registered read port.
//   Register 0 (arena_granules) sits at byte address 0 of the APB port.
//   Reset, or a write of that register, passes through an init state (busy high)
//   that writes the header of the single chunk that covers the whole arena.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [0:0]  i_cmd,
    input  logic [16:0] i_request_bytes,
    input  logic [15:0] i_block_offset,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_granted_offset,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffba_pkg::*;

    t_dp_cmd     cmd_bus;
    t_dp_stat    stat;
    logic        cfg_we;
    logic [12:0] arena;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {19'd0, arena} : 32'd0;

    ffba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (cfg_we),
        .i_start  (start),
        .i_stat   (stat),
        .o_cmd_bus(cmd_bus),
        .o_busy   (busy)
    );

    ffba_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_bus       (cmd_bus),
        .o_stat          (stat),
        .i_cfg_we        (cfg_we),
        .i_cfg_value     (pwdata[12:0]),
        .o_arena         (arena),
        .i_cmd           (i_cmd[0]),
        .i_request_bytes (i_request_bytes),
        .i_block_offset  (i_block_offset),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_granted_offset(o_granted_offset)
    );
endmodule

@@ src/ffba_ram.sv @@
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/ffba_datapath.sv @@
// ----------------------------------------------------------------------------
// ffba_datapath
// List pointers, header RAM, arena size and result registers.
// ----------------------------------------------------------------------------
module ffba_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ffba_pkg::t_dp_cmd  i_cmd_bus,
    output ffba_pkg::t_dp_stat o_stat,
    input  logic               i_cfg_we,
    input  logic [12:0]        i_cfg_value,
    output logic [12:0]        o_arena,
    input  logic               i_cmd,
    input  logic [16:0]        i_request_bytes,
    input  logic [15:0]        i_block_offset,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [15:0]        o_granted_offset
);
    import ffba_pkg::*;

    logic [LW-1:0] r_arena, r_head, r_cur, r_prev, r_steps, r_need, r_s, r_nn, r_ts;
    logic [IW-1:0] r_t;
    logic          r_cmd, r_zero;
    t_hdr          r_prev_hdr, r_nx_hdr, rdata;
    logic          r_valid;
    logic [1:0]    r_status;
    logic [15:0]   r_granted;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    t_hdr          wdata;
    logic [LW-1:0] t_ext, s_cur, ps, nxs, repl, rem_addr, cfg_v;
    logic [17:0]   need_sum;
    logic          prev_ok;

    assign t_ext   = {1'b0, r_t};
    assign s_cur   = eff_size(r_cur, rdata.size, r_arena);
    assign ps      = eff_size(r_prev, r_prev_hdr.size, r_arena);
    assign nxs     = eff_size(r_cur, r_nx_hdr.size, r_arena);
    assign prev_ok = r_prev < r_arena;
    assign rem_addr = r_cur + r_need;
    assign repl    = (r_s != r_need) ? rem_addr : r_nn;
    assign need_sum = {1'b0, i_request_bytes} + 18'd23;

    assign o_stat.is_free   = r_cmd != CMD_ALLOC;
    assign o_stat.zero_req  = r_zero;
    assign o_stat.walk_ok   = (r_cur < r_arena) && (r_steps < r_arena);
    assign o_stat.fit       = s_cur >= r_need;
    assign o_stat.split     = r_s != r_need;
    assign o_stat.t_oor     = t_ext >= r_arena;
    assign o_stat.walk_more = (r_cur < r_arena) && (r_cur < t_ext) && (r_steps < r_arena);
    assign o_stat.nmerge    = (r_cur < r_arena)
                            && ({1'b0, t_ext} + {1'b0, r_ts} == {1'b0, r_cur});
    assign o_stat.prev_adj  = prev_ok && ({1'b0, r_prev} + {1'b0, ps} == {1'b0, t_ext});

    assign raddr = (i_cmd_bus.op == OP_RD_T) ? r_t : r_cur[IW-1:0];

    always_comb begin
        we    = 1'b0;
        waddr = r_cur[IW-1:0];
        wdata = '{next: r_nn, size: r_need};
        case (i_cmd_bus.op)
            OP_INIT: begin
                we    = 1'b1;
                waddr = '0;
                wdata = '{next: NULL_LINK, size: r_arena};
            end
            OP_WR_REM: begin
                we    = 1'b1;
                waddr = rem_addr[IW-1:0];
                wdata = '{next: r_nn, size: r_s - r_need};
            end
            OP_WR_PREVA: begin
                we    = prev_ok;
                waddr = r_prev[IW-1:0];
                wdata = '{next: repl, size: r_prev_hdr.size};
            end
            OP_WR_CUR: begin
                we = 1'b1;
            end
            OP_WR_PMRG: begin
                we    = 1'b1;
                waddr = r_prev[IW-1:0];
                wdata = o_stat.nmerge ? '{next: r_nx_hdr.next, size: ps + r_ts + nxs}
                                      : '{next: r_cur, size: ps + r_ts};
            end
            OP_WR_PLINK: begin
                we    = prev_ok;
                waddr = r_prev[IW-1:0];
                wdata = '{next: t_ext, size: r_prev_hdr.size};
            end
            OP_WR_T: begin
                we    = 1'b1;
                waddr = r_t;
                wdata = o_stat.nmerge ? '{next: r_nx_hdr.next, size: r_ts + nxs}
                                      : '{next: r_cur, size: r_ts};
            end
            default: begin
            end
        endcase
    end

    ffba_ram #(.WIDTH(2 * LW), .DEPTH(ARENA_GRANULES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // written value 0 is taken as 1, anything above ARENA_GRANULES as ARENA_GRANULES
    assign cfg_v = (i_cfg_value == '0) ? LW'(1)
                 : (i_cfg_value > NULL_LINK) ? NULL_LINK : i_cfg_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena <= NULL_LINK;
            r_head  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd_bus.emit;
            if (i_cfg_we) begin
                r_arena <= cfg_v;
            end
            if (i_cmd_bus.op == OP_INIT) begin
                r_head <= '0;
            end else if (i_cmd_bus.op == OP_WR_PREVA && !prev_ok) begin
                r_head <= repl;
            end else if (i_cmd_bus.op == OP_WR_PLINK && !prev_ok) begin
                r_head <= t_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd_bus.op)
            OP_START: begin
                r_cmd   <= i_cmd;
                r_zero  <= i_request_bytes == '0;
                r_need  <= need_sum[16:4];
                r_t     <= i_block_offset[15:4];
                r_cur   <= r_head;
                r_prev  <= NULL_LINK;
                r_steps <= '0;
            end
            OP_STEP: begin
                r_prev     <= r_cur;
                r_prev_hdr <= rdata;
                r_cur      <= rdata.next;
                r_steps    <= r_steps + 1'b1;
            end
            OP_FIT: begin
                r_s  <= s_cur;
                r_nn <= rdata.next;
            end
            OP_LATCH_T: begin
                r_ts <= eff_size(t_ext, rdata.size, r_arena);
            end
            OP_LATCH_NX: begin
                r_nx_hdr <= rdata;
            end
            default: begin
            end
        endcase
        if (i_cmd_bus.emit) begin
            r_status  <= i_cmd_bus.status;
            r_granted <= (i_cmd_bus.status == ST_DONE && r_cmd == CMD_ALLOC)
                       ? {r_cur[IW-1:0], 4'h8} : 16'd0;
        end
    end

    assign o_arena          = r_arena;
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_granted_offset = r_granted;
endmodule

@@ src/ffba_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for list init, allocate walk/split and free walk/merge.
// ----------------------------------------------------------------------------
module ffba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_start,
    input  ffba_pkg::t_dp_stat i_stat,
    output ffba_pkg::t_dp_cmd  o_cmd_bus,
    output logic               o_busy
);
    import ffba_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A_CHK = 4'd2;
    localparam logic [3:0] S_A_RD  = 4'd3;
    localparam logic [3:0] S_A_W1  = 4'd4;
    localparam logic [3:0] S_A_W2  = 4'd5;
    localparam logic [3:0] S_A_W3  = 4'd6;
    localparam logic [3:0] S_F_CHK0 = 4'd7;
    localparam logic [3:0] S_F_LT  = 4'd8;
    localparam logic [3:0] S_F_CHK = 4'd9;
    localparam logic [3:0] S_F_RD  = 4'd10;
    localparam logic [3:0] S_F_NX  = 4'd11;
    localparam logic [3:0] S_F_WR  = 4'd12;
    localparam logic [3:0] S_F_WT  = 4'd13;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd_bus = '{op: OP_NONE, emit: 1'b0, status: ST_DONE};
        case (r_state)
            S_INIT: begin
                o_cmd_bus.op = OP_INIT;
                n_state      = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd_bus.op = OP_START;
                    n_state      = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (i_stat.is_free) begin
                    n_state = S_F_CHK0;
                end else if (i_stat.zero_req) begin
                    o_cmd_bus.emit   = 1'b1;
                    o_cmd_bus.status = ST_ZERO;
                    n_state          = S_IDLE;
                end else if (i_stat.walk_ok) begin
                    o_cmd_bus.op = OP_RD_CUR;
                    n_state      = S_A_RD;
                end else begin
                    o_cmd_bus.emit   = 1'b1;
                    o_cmd_bus.status = ST_NOFIT;
                    n_state          = S_IDLE;
                end
            end
            S_A_RD: begin
                o_cmd_bus.op = i_stat.fit ? OP_FIT : OP_STEP;
                n_state      = i_stat.fit ? S_A_W1 : S_A_CHK;
            end
            S_A_W1: begin
                if (i_stat.split) begin
                    o_cmd_bus.op = OP_WR_REM;
                end
                n_state = S_A_W2;
            end
            S_A_W2: begin
                o_cmd_bus.op = OP_WR_PREVA;
                n_state      = S_A_W3;
            end
            S_A_W3: begin
                o_cmd_bus.op   = OP_WR_CUR;
                o_cmd_bus.emit = 1'b1;
                n_state        = S_IDLE;
            end
            S_F_CHK0: begin
                if (i_stat.t_oor) begin
                    o_cmd_bus.emit = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd_bus.op = OP_RD_T;
                    n_state      = S_F_LT;
                end
            end
            S_F_LT: begin
                o_cmd_bus.op = OP_LATCH_T;
                n_state      = S_F_CHK;
            end
            S_F_CHK: begin
                if (i_stat.walk_more) begin
                    o_cmd_bus.op = OP_RD_CUR;
                    n_state      = S_F_RD;
                end else if (i_stat.nmerge) begin
                    o_cmd_bus.op = OP_RD_CUR;
                    n_state      = S_F_NX;
                end else begin
                    n_state = S_F_WR;
                end
            end
            S_F_RD: begin
                o_cmd_bus.op = OP_STEP;
                n_state      = S_F_CHK;
            end
            S_F_NX: begin
                o_cmd_bus.op = OP_LATCH_NX;
                n_state      = S_F_WR;
            end
            S_F_WR: begin
                if (i_stat.prev_adj) begin
                    o_cmd_bus.op   = OP_WR_PMRG;
                    o_cmd_bus.emit = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd_bus.op = OP_WR_PLINK;
                    n_state      = S_F_WT;
                end
            end
            S_F_WT: begin
                o_cmd_bus.op   = OP_WR_T;
                o_cmd_bus.emit = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        if (i_cfg_we) begin
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;
endmodule

@@ verif/ffba_checker.sv @@
// ----------------------------------------------------------------------------
// ffba_checker
// Watches the request, result and APB channels of the first-fit allocator,
// keeps its own copy of the free list, and compares every result it sees.
// ----------------------------------------------------------------------------
module ffba_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [0:0]  i_cmd,
    input  logic [16:0] i_request_bytes,
    input  logic [15:0] i_block_offset,
    input  logic        i_valid,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_granted_offset,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffba_pkg::*;

    localparam int ADDR_ARENA = 0;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] granted;
    } t_grant;

    logic [12:0] arena_sz;
    logic [12:0] head_chunk;
    logic [12:0] link_mem [ARENA_GRANULES];
    logic [12:0] size_mem [ARENA_GRANULES];
    t_grant      grants_due [$];

    assign o_pending = grants_due.size();

    initial o_fail_count = 0;

    task automatic report_mismatch(input string msg);
        if (o_fail_count < 40)
            $display("[%0t] ERROR %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic bit in_arena(input int unsigned c);
        return c < arena_sz;
    endfunction

    function automatic int unsigned chunk_len(input int unsigned c);
        int unsigned s;
        int unsigned room;
        s    = size_mem[c];
        room = arena_sz - c;
        if (s == 0) s = 1;
        if (s > room) s = room;
        return s;
    endfunction

    function automatic void rebuild_list();
        head_chunk  = '0;
        link_mem[0] = 13'(ARENA_GRANULES);
        size_mem[0] = arena_sz;
    endfunction

    function automatic t_grant take_chunk(input int unsigned bytes);
        t_grant      r;
        int unsigned need, prv, cur, steps, s, nn, repl, rem;
        r.status  = ST_NOFIT;
        r.granted = '0;
        if (bytes == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        need  = (bytes + 8 + 15) >> 4;
        prv   = ARENA_GRANULES;
        cur   = head_chunk;
        steps = 0;
        while (in_arena(cur) && steps < arena_sz) begin
            s = chunk_len(cur);
            if (s >= need) begin
                nn = link_mem[cur];
                if (s == need) begin
                    repl = nn;
                end else begin
                    rem = cur + need;
                    link_mem[rem] = 13'(nn);
                    size_mem[rem] = 13'(s - need);
                    repl = rem;
                end
                if (in_arena(prv)) link_mem[prv] = 13'(repl);
                else head_chunk = 13'(repl);
                size_mem[cur] = 13'(need);
                r.status  = ST_DONE;
                r.granted = 16'(cur * 16 + 8);
                return r;
            end
            prv = cur;
            cur = link_mem[cur];
            steps++;
        end
        return r;
    endfunction

    function automatic void return_chunk(input int unsigned offset);
        int unsigned t, ts, prv, nx, steps, ps;
        bit          nmerge;
        t = offset >> 4;
        if (t >= arena_sz) return;
        ts    = chunk_len(t);
        prv   = ARENA_GRANULES;
        nx    = head_chunk;
        steps = 0;
        while (in_arena(nx) && nx < t && steps < arena_sz) begin
            prv = nx;
            nx  = link_mem[nx];
            steps++;
        end
        nmerge = in_arena(nx) && (t + ts == nx);
        if (in_arena(prv)) begin
            ps = chunk_len(prv);
            if (prv + ps == t) begin
                if (nmerge) begin
                    link_mem[prv] = link_mem[nx];
                    size_mem[prv] = 13'(ps + ts + chunk_len(nx));
                end else begin
                    link_mem[prv] = 13'(nx);
                    size_mem[prv] = 13'(ps + ts);
                end
                return;
            end
            link_mem[prv] = 13'(t);
        end else begin
            head_chunk = 13'(t);
        end
        if (nmerge) begin
            link_mem[t] = link_mem[nx];
            size_mem[t] = 13'(ts + chunk_len(nx));
        end else begin
            link_mem[t] = 13'(nx);
            size_mem[t] = 13'(ts);
        end
    endfunction

    always @(posedge i_clk) begin
        t_grant      exp_r;
        t_grant      got;
        int unsigned v;
        if (!i_rst_n) begin
            for (int i = 0; i < ARENA_GRANULES; i++) begin
                link_mem[i] = '0;
                size_mem[i] = '0;
            end
            arena_sz = 13'(ARENA_GRANULES);
            rebuild_list();
            grants_due.delete();
        end else begin
            if (i_valid) begin
                if (grants_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status=%0d offset=%0d",
                                              i_status, i_granted_offset));
                end else begin
                    exp_r = grants_due.pop_front();
                    if (i_status !== exp_r.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, exp_r.status));
                    if (i_granted_offset !== exp_r.granted)
                        report_mismatch($sformatf("granted_offset %0d, expected %0d",
                                                  i_granted_offset, exp_r.granted));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_ARENA) begin
                v = i_pwdata & 32'h1FFF;
                if (v == 0) v = 1;
                if (v > ARENA_GRANULES) v = ARENA_GRANULES;
                arena_sz = 13'(v);
                rebuild_list();
            end
            if (i_start && !i_busy) begin
                if (i_cmd == CMD_ALLOC) begin
                    got = take_chunk(i_request_bytes);
                end else begin
                    return_chunk(i_block_offset);
                    got.status  = ST_DONE;
                    got.granted = '0;
                end
                grants_due.push_back(got);
            end
        end
    end

endmodule

@@ verif/tb_first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Drives allocate and free requests and arena size writes into the allocator;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import ffba_pkg::*;

    localparam int STALL_LIMIT  = 60000;
    localparam int PHASE_ITEMS  = 300;
    localparam bit CMD_FREE     = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [0:0]  i_cmd;
    logic [16:0] i_request_bytes;
    logic [15:0] i_block_offset;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_granted_offset;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    logic [0:0]  cmds_in_flight [$];
    logic [15:0] live_blocks [$];
    int          arena_now;
    int          idle_pct;
    int          stall_cycles;

    first_fit_block_allocator dut (.*);

    ffba_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_cmd(i_cmd), .i_request_bytes(i_request_bytes),
        .i_block_offset(i_block_offset), .i_valid(o_valid), .i_status(o_status),
        .i_granted_offset(o_granted_offset), .i_psel(psel), .i_penable(penable),
        .i_pwrite(pwrite), .i_pready(pready), .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // live allocations, learned from the results
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) cmds_in_flight.push_back(i_cmd);
        if (i_rst_n && o_valid && cmds_in_flight.size() != 0) begin
            if (cmds_in_flight.pop_front() == CMD_ALLOC && o_status == ST_DONE)
                live_blocks.push_back(o_granted_offset);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("first_fit_block_allocator: mismatch");
                $finish;
            end
        end
    end

    task automatic issue(input logic [0:0] cmd, input int unsigned bytes,
                         input int unsigned offset);
        int gap;
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_request_bytes <= 17'(bytes);
        i_block_offset  <= 16'(offset);
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(4, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_arena(input int unsigned value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= '0;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        v_clamp(value);
        live_blocks.delete();
    endtask

    function automatic void v_clamp(input int unsigned value);
        int unsigned v;
        v = value & 32'h1FFF;
        if (v == 0) v = 1;
        if (v > ARENA_GRANULES) v = ARENA_GRANULES;
        arena_now = v;
    endfunction

    task automatic random_item();
        int          pick, idx;
        int unsigned bytes, t;
        logic [15:0] blk;
        pick = $urandom_range(99);
        if (pick < 40 && live_blocks.size() != 0) begin
            idx = $urandom_range(live_blocks.size() - 1);
            blk = live_blocks[idx];
            live_blocks.delete(idx);
            // any low nibble names the same granule
            issue(CMD_FREE, $urandom_range(131071), {blk[15:4], 4'($urandom)});
        end else if (pick < 46 && arena_now < ARENA_GRANULES) begin
            t = $urandom_range(ARENA_GRANULES - 1, arena_now);
            issue(CMD_FREE, $urandom, t * 16 + $urandom_range(15));
        end else begin
            pick = $urandom_range(99);
            if (pick < 8)       bytes = 0;
            else if (pick < 16) bytes = $urandom_range(65536);
            else if (pick < 30) bytes = $urandom_range(2048, 1);
            else                bytes = $urandom_range(120, 1);
            issue(CMD_ALLOC, bytes, $urandom);
        end
    endtask

    initial begin
        int unsigned arena_plan [6];
        arena_plan = '{4096, 1, 0, 32'hFFFF_E000 | 8191, 37, 300};
        i_rst_n = 1'b0;
        start = 1'b0; i_cmd = '0; i_request_bytes = '0; i_block_offset = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        arena_now = ARENA_GRANULES;
        idle_pct = 11;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // whole arena, zero size, oversize, exact fit, then merge cases
        issue(CMD_ALLOC, 0, 16'hFFFF);
        issue(CMD_ALLOC, 65536, 0);
        issue(CMD_ALLOC, 65527, 0);
        issue(CMD_ALLOC, 1, 0);
        issue(CMD_FREE, 131071, 15);
        issue(CMD_ALLOC, 24, 0);
        issue(CMD_ALLOC, 17, 0);
        issue(CMD_ALLOC, 24, 0);
        issue(CMD_ALLOC, 20, 0);
        issue(CMD_FREE, 0, 44);     // ahead of the head, no neighbor free
        issue(CMD_FREE, 0, 96);     // joins the chunk above
        issue(CMD_FREE, 0, 72);     // joins both sides
        issue(CMD_FREE, 0, 8);      // back to one chunk
        issue(CMD_ALLOC, 8, 0);
        issue(CMD_ALLOC, 9, 0);
        drain();
        live_blocks.delete();

        for (int ph = 0; ph < 6; ph++) begin
            idle_pct = (ph < 2) ? 11 : (ph < 4) ? 52 : 0;
            write_arena(arena_plan[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
                if (n == PHASE_ITEMS / 2) drain();
            end
            drain();
        end
        write_arena(ARENA_GRANULES);
        repeat (20) random_item();
        drain();

        if (fail_count == 0) begin
            $display("first_fit_block_allocator: match");
        end else begin
            $display("first_fit_block_allocator: mismatch");
        end
        $finish;
    end

endmodule
